/* rtl/adc_window_average_ntc_convert_top_assert.svh */
// assertion macros shared by the checker of the window averager
// no dependencies; included by bare file name
`ifndef ADC_WINDOW_AVERAGE_NTC_CONVERT_TOP_ASSERT_SVH
`define ADC_WINDOW_AVERAGE_NTC_CONVERT_TOP_ASSERT_SVH

// clocked check, muted while reset is high
`define AWNC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds across reset
`define AWNC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/awnc_pkg.sv */
// shared types and fixed constants of the adc window averager
// no dependencies
package awnc_pkg;

   typedef logic [1:0]        kind_type;
   typedef logic [1:0]        status_type;
   typedef logic signed [14:0] temp_type;

   // reading kinds
   localparam kind_type KIND_PRESSURE   = 2'd0;
   localparam kind_type KIND_VALVE      = 2'd1;
   localparam kind_type KIND_THERMISTOR = 2'd2;
   localparam kind_type KIND_NONE       = 2'd3;

   // temperature status
   localparam status_type ST_VALID = 2'd0;
   localparam status_type ST_CLAMP = 2'd1;
   localparam status_type ST_ZERO  = 2'd2;
   localparam status_type ST_NONE  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_BETA       = 3'd0;
   localparam logic [2:0] REG_REF_RATIO  = 3'd1;
   localparam logic [2:0] REG_NTC_FIRST  = 3'd2;
   localparam logic [2:0] REG_NTC_COUNT  = 3'd3;
   localparam logic [2:0] REG_PRESS_CNT  = 3'd4;
   localparam logic [2:0] REG_VALVE_CH   = 3'd5;

   // register reset values
   localparam logic [15:0] BETA_RST      = 16'd3950;
   localparam logic [19:0] REF_RATIO_RST = 20'd10000;
   localparam logic [3:0]  NTC_FIRST_RST = 4'd4;
   localparam logic [4:0]  NTC_COUNT_RST = 5'd6;
   localparam logic [4:0]  PRESS_CNT_RST = 5'd3;
   localparam logic [3:0]  VALVE_CH_RST  = 4'd3;

   // serial divider width
   localparam int DIV_W = 48;

   // fixed point constants of the beta equation
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [63:0] INV_T25_Q40 = ((64'd1 << 40) * 64'd20 + 64'd2981) / 64'd5963;
   localparam logic [DIV_W-1:0] CENTI_Q40 = DIV_W'(64'd100 << 40);
   localparam int LN_SHIFT = 24;
   localparam logic [15:0] KELVIN_CENTI = 16'd27315;
   // kelvin centi bounds that map onto -40 C and 150 C
   localparam logic [DIV_W-1:0] T_LOW_K  = DIV_W'(23315);
   localparam logic [DIV_W-1:0] T_HIGH_K = DIV_W'(42315);
   localparam temp_type T_LOW  = -15'sd4000;
   localparam temp_type T_HIGH = 15'sd15000;
   localparam logic [9:0] LOG_MILLI = 10'd1000;
   localparam logic [6:0] VALVE_DIV = 7'd100;

endpackage

/* rtl/adc_window_average_ntc_convert_top.sv */
// adc window averager with thermistor beta conversion, top level
// uses awnc_pkg, awnc_ram, awnc_div and awnc_log2
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| req_channel, req_sample
//   rsp     | out       | rsp_valid/rsp_stall| channel, kind, average, temp, status, valve
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// one request at a time; a pressure or unassigned channel takes one serial division,
// the valve channel two and a thermistor up to four log2 runs plus three serial divisions
// (average, beta and reciprocal), all on the shared divider and the log2 squaring unit
// synchronous active high reset; no clearing pass, a per-channel wrap flag stands in
// for the zeroed sample store; a stalled response holds while the next request runs
module adc_window_average_ntc_convert_top #(
   parameter int CHANNELS    = 16,
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [3:0]              req_channel,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [3:0]              rsp_channel_out,
   output awnc_pkg::kind_type      rsp_reading_kind,
   output logic [15:0]             rsp_average_q4,
   output awnc_pkg::temp_type      rsp_temperature_centi,
   output awnc_pkg::status_type    rsp_temp_status,
   output logic [13:0]             rsp_valve_position_q8,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [19:0]             csr_wdata
);
   import awnc_pkg::*;

   localparam int CH_W  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int POS_W = WINDOW > 1 ? $clog2(WINDOW) : 1;
   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW + 1);
   localparam int AVG_W = SAMPLE_BITS + 4;
   localparam int LOG_W = (SAMPLE_BITS + 5 > 20) ? SAMPLE_BITS + 5 : 20;
   localparam int RES_W = $clog2(LOG_W) + 16;
   localparam int D_W   = RES_W + 3;
   localparam int INV_W = DIV_W + 2;
   localparam logic [AVG_W:0] FULL_Q4 = (AVG_W + 1)'(1) << AVG_W;

   // sequencer codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_SUM    = 4'd2;
   localparam logic [3:0] S_AVG    = 4'd3;
   localparam logic [3:0] S_CLASS  = 4'd4;
   localparam logic [3:0] S_LOG    = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_BSTART = 4'd7;
   localparam logic [3:0] S_BDIV   = 4'd8;
   localparam logic [3:0] S_INV    = 4'd9;
   localparam logic [3:0] S_TDIV   = 4'd10;
   localparam logic [3:0] S_VALVE  = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   // configuration registers
   logic [15:0] beta_ff;
   logic [19:0] ref_ff;
   logic [3:0]  ntc_first_ff;
   logic [4:0]  ntc_count_ff;
   logic [4:0]  press_cnt_ff;
   logic [3:0]  valve_ch_ff;

   // per-channel window state
   logic [SUM_W-1:0] sums_ff [CHANNELS];
   logic [SUM_W-1:0] sums_in [CHANNELS];
   logic [POS_W-1:0] pos_ff  [CHANNELS];
   logic [POS_W-1:0] pos_in  [CHANNELS];
   logic [CHANNELS-1:0] wrap_ff, wrap_in;

   // request in flight
   logic [3:0]             state_ff, state_in;
   logic [3:0]             ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic [AVG_W-1:0]       avg_ff, avg_in;
   kind_type               kind_ff, kind_in;
   status_type             status_ff, status_in;
   temp_type               temp_ff, temp_in;
   logic [13:0]            valve_ff, valve_in;
   logic signed [D_W-1:0]  d_ff, d_in;
   logic [1:0]             step_ff, step_in;
   logic [D_W-1:0]         ln_ff, ln_in;
   logic signed [INV_W-1:0] inv_ff, inv_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  o_ch_ff;
   kind_type    o_kind_ff;
   logic [15:0] o_avg_ff;
   temp_type    o_temp_ff;
   status_type  o_status_ff;
   logic [13:0] o_valve_ff;

   // datapath helpers
   logic [CH_W-1:0]        ch_idx;
   logic [AW-1:0]          addr;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   logic [SAMPLE_BITS-1:0] old_smp;
   logic [SUM_W-1:0]       sum_new;
   logic                   ram_we;
   logic                   is_ntc, is_valve, is_press;
   logic [15:0]            beta_eff;
   logic [19:0]            ref_eff;
   logic                   div_start, div_done;
   logic [DIV_W-1:0]       div_num, div_den, div_q;
   logic                   log_start, log_done;
   logic [1:0]             log_sel;
   logic [LOG_W-1:0]       log_x;
   logic [RES_W-1:0]       log_res;
   logic signed [D_W-1:0]  log_ext;
   logic [D_W-1:0]         d_mag;
   logic [D_W+29:0]        ln_prod;
   logic signed [INV_W-1:0] q_signed;
   logic                   out_free;

   assign ch_idx   = CH_W'(ch_ff);
   assign addr     = AW'(int'(ch_idx) * WINDOW + int'(pos_ff[ch_idx]));
   assign old_smp  = wrap_ff[ch_idx] ? ram_rdata : '0;
   assign sum_new  = sums_ff[ch_idx] - SUM_W'(old_smp) + SUM_W'(smp_ff);
   assign ram_we   = (state_ff == S_SUM);
   assign beta_eff = (beta_ff == '0) ? 16'd1 : beta_ff;
   assign ref_eff  = (ref_ff == '0) ? 20'd1 : ref_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // thermistor range wins over valve, valve over pressure
   assign is_ntc   = ({2'b0, ch_ff} >= {2'b0, ntc_first_ff}) &&
                     ({2'b0, ch_ff} < ({2'b0, ntc_first_ff} + {1'b0, ntc_count_ff}));
   assign is_valve = (ch_ff == valve_ch_ff);
   assign is_press = ({1'b0, ch_ff} < press_cnt_ff);

   // d accumulates +log(avg) -log(full-avg) +log(1000) -log(ref)
   assign log_ext = $signed(D_W'(log_res));
   assign d_mag   = d_ff[D_W-1] ? D_W'(-d_ff) : D_W'(d_ff);
   assign ln_prod = (D_W + 30)'(d_mag) * (D_W + 30)'(LN2_Q30);
   assign q_signed = $signed(INV_W'(div_q));

   always_comb begin
      case (log_sel)
         2'd0:    log_x = LOG_W'(avg_ff);
         2'd1:    log_x = LOG_W'(FULL_Q4 - {1'b0, avg_ff});
         2'd2:    log_x = LOG_W'(LOG_MILLI);
         default: log_x = LOG_W'(ref_eff);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      avg_in       = avg_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      temp_in      = temp_ff;
      valve_in     = valve_ff;
      d_in         = d_ff;
      step_in      = step_ff;
      ln_in        = ln_ff;
      inv_in       = inv_ff;
      sums_in      = sums_ff;
      pos_in       = pos_ff;
      wrap_in      = wrap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = DIV_W'(1);
      log_start    = 1'b0;
      log_sel      = step_ff + 2'd1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in     = req_channel;
               smp_in    = req_sample;
               avg_in    = '0;
               kind_in   = KIND_NONE;
               status_in = ST_NONE;
               temp_in   = '0;
               valve_in  = '0;
               // channels past the store go straight out
               state_in  = (int'(req_channel) < CHANNELS) ? S_READ : S_OUT;
            end
         end
         S_READ: state_in = S_SUM;
         S_SUM: begin
            sums_in[ch_idx] = sum_new;
            if (int'(pos_ff[ch_idx]) == WINDOW - 1) begin
               pos_in[ch_idx]  = '0;
               wrap_in[ch_idx] = 1'b1;
            end else begin
               pos_in[ch_idx] = pos_ff[ch_idx] + 1'b1;
            end
            div_start = 1'b1;
            div_num   = DIV_W'(sum_new) << 4;
            div_den   = DIV_W'(WINDOW);
            state_in  = S_AVG;
         end
         S_AVG: begin
            if (div_done) begin
               avg_in   = AVG_W'(div_q);
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (is_ntc) begin
               kind_in = KIND_THERMISTOR;
               if (avg_ff == '0) begin
                  temp_in   = T_LOW;
                  status_in = ST_ZERO;
                  state_in  = S_OUT;
               end else begin
                  log_sel   = 2'd0;
                  log_start = 1'b1;
                  step_in   = 2'd0;
                  d_in      = '0;
                  state_in  = S_LOG;
               end
            end else if (is_valve) begin
               kind_in   = KIND_VALVE;
               div_start = 1'b1;
               div_num   = DIV_W'(avg_ff) << 4;
               div_den   = DIV_W'(VALVE_DIV);
               state_in  = S_VALVE;
            end else begin
               if (is_press) begin
                  kind_in = KIND_PRESSURE;
               end
               state_in = S_OUT;
            end
         end
         S_LOG: begin
            if (log_done) begin
               d_in = step_ff[0] ? d_ff - log_ext : d_ff + log_ext;
               if (step_ff == 2'd3) begin
                  state_in = S_MUL;
               end else begin
                  log_start = 1'b1;
                  step_in   = step_ff + 2'd1;
               end
            end
         end
         S_MUL: begin
            ln_in    = D_W'(ln_prod >> 30);
            state_in = S_BSTART;
         end
         S_BSTART: begin
            div_start = 1'b1;
            div_num   = DIV_W'(ln_ff) << LN_SHIFT;
            div_den   = DIV_W'(beta_eff);
            state_in  = S_BDIV;
         end
         S_BDIV: begin
            if (div_done) begin
               inv_in   = $signed(INV_W'(INV_T25_Q40)) +
                          (d_ff[D_W-1] ? -q_signed : q_signed);
               state_in = S_INV;
            end
         end
         S_INV: begin
            if (inv_ff <= 0) begin
               temp_in   = T_LOW;
               status_in = ST_CLAMP;
               state_in  = S_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = CENTI_Q40 + DIV_W'(inv_ff >>> 1);
               div_den   = DIV_W'(inv_ff);
               state_in  = S_TDIV;
            end
         end
         S_TDIV: begin
            if (div_done) begin
               if (div_q < T_LOW_K) begin
                  temp_in   = T_LOW;
                  status_in = ST_CLAMP;
               end else if (div_q > T_HIGH_K) begin
                  temp_in   = T_HIGH;
                  status_in = ST_CLAMP;
               end else begin
                  temp_in   = temp_type'(div_q[15:0] - KELVIN_CENTI);
                  status_in = ST_VALID;
               end
               state_in = S_OUT;
            end
         end
         S_VALVE: begin
            if (div_done) begin
               valve_in = 14'(div_q);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // response slot free: hand over and take the next request
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wrap_ff      <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
         beta_ff      <= BETA_RST;
         ref_ff       <= REF_RATIO_RST;
         ntc_first_ff <= NTC_FIRST_RST;
         ntc_count_ff <= NTC_COUNT_RST;
         press_cnt_ff <= PRESS_CNT_RST;
         valve_ch_ff  <= VALVE_CH_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wrap_ff      <= wrap_in;
         sums_ff      <= sums_in;
         pos_ff       <= pos_in;
         if (csr_we) begin
            case (csr_index)
               REG_BETA:      beta_ff      <= csr_wdata[15:0];
               REG_REF_RATIO: ref_ff       <= csr_wdata;
               REG_NTC_FIRST: ntc_first_ff <= csr_wdata[3:0];
               REG_NTC_COUNT: ntc_count_ff <= csr_wdata[4:0];
               REG_PRESS_CNT: press_cnt_ff <= csr_wdata[4:0];
               REG_VALVE_CH:  valve_ch_ff  <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
      ch_ff     <= ch_in;
      smp_ff    <= smp_in;
      avg_ff    <= avg_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      temp_ff   <= temp_in;
      valve_ff  <= valve_in;
      d_ff      <= d_in;
      step_ff   <= step_in;
      ln_ff     <= ln_in;
      inv_ff    <= inv_in;
      if (state_ff == S_OUT && out_free) begin
         o_ch_ff     <= ch_ff;
         o_kind_ff   <= kind_ff;
         o_avg_ff    <= 16'(avg_ff);
         o_temp_ff   <= temp_ff;
         o_status_ff <= status_ff;
         o_valve_ff  <= valve_ff;
      end
   end

   // sample ring of all channels
   awnc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr),
      .wdata (smp_ff),
      .raddr (addr),
      .rdata (ram_rdata)
   );

   // shared serial divider: window average, valve scale, beta and reciprocal
   awnc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   awnc_log2 #(
      .LOG_W (LOG_W)
   ) u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_channel_out       = o_ch_ff;
   assign rsp_reading_kind      = o_kind_ff;
   assign rsp_average_q4        = o_avg_ff;
   assign rsp_temperature_centi = o_temp_ff;
   assign rsp_temp_status       = o_status_ff;
   assign rsp_valve_position_q8 = o_valve_ff;
endmodule

/* rtl/awnc_ram.sv */
// generic single write port ram with registered read
// no dependencies
module awnc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 160
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/awnc_div.sv */
// restoring divider, one quotient bit per cycle
// uses awnc_pkg for the datapath width
module awnc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [awnc_pkg::DIV_W-1:0]  num,
   input  logic [awnc_pkg::DIV_W-1:0]  den,
   output logic                        done,
   output logic [awnc_pkg::DIV_W-1:0]  quotient
);
   import awnc_pkg::*;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, den_ff}) : DIV_W'(trial);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/awnc_log2.sv */
// log2 in q16: one-bit normalize shifts, then one mantissa squaring per cycle
// uses awnc_pkg
module awnc_log2 #(
   parameter int LOG_W = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [LOG_W-1:0]                   x,
   output logic                               done,
   output logic [$clog2(LOG_W)+16-1:0]        result
);
   import awnc_pkg::*;
   localparam int K_W = $clog2(LOG_W);
   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_NORM = 2'd1;
   localparam logic [1:0] L_SQ   = 2'd2;

   logic [1:0]       st_ff, st_in;
   logic [LOG_W-1:0] xn_ff, xn_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [30:0]      m_ff, m_in;
   logic [15:0]      frac_ff, frac_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [61:0]      sq;
   logic [31:0]      sq_hi;

   always_comb begin
      sq      = 62'(m_ff) * 62'(m_ff);
      sq_hi   = sq[61:30];
      st_in   = st_ff;
      xn_in   = xn_ff;
      k_in    = k_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      case (st_ff)
         L_IDLE: begin
            if (start) begin
               xn_in   = (x == '0) ? LOG_W'(1) : x;
               k_in    = K_W'(LOG_W - 1);
               frac_in = '0;
               st_in   = L_NORM;
            end
         end
         L_NORM: begin
            if (xn_ff[LOG_W-1]) begin
               m_in   = {xn_ff, {(31 - LOG_W){1'b0}}};
               cnt_in = 4'd15;
               st_in  = L_SQ;
            end else begin
               xn_in = {xn_ff[LOG_W-2:0], 1'b0};
               k_in  = k_ff - 1'b1;
            end
         end
         L_SQ: begin
            if (sq_hi[31]) begin
               m_in            = sq_hi[31:1];
               frac_in[cnt_ff] = 1'b1;
            end else begin
               m_in = sq_hi[30:0];
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 4'd0) begin
               st_in   = L_IDLE;
               done_in = 1'b1;
            end
         end
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      xn_ff   <= xn_in;
      k_ff    <= k_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = {k_ff, frac_ff};
endmodule

/* rtl/awnc_checker.sv */
// port level checks of the window averager response channel
// uses awnc_pkg and adc_window_average_ntc_convert_top_assert.svh
`include "adc_window_average_ntc_convert_top_assert.svh"

module awnc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [3:0]           rsp_channel_out,
   input awnc_pkg::kind_type   rsp_reading_kind,
   input logic [15:0]          rsp_average_q4,
   input awnc_pkg::temp_type   rsp_temperature_centi,
   input awnc_pkg::status_type rsp_temp_status,
   input logic [13:0]          rsp_valve_position_q8
);
   import awnc_pkg::*;

   logic        rsp_held;
   logic        is_therm, has_temp, is_valve;
   logic [52:0] rsp_word;

   assign rsp_held = rsp_valid && rsp_stall;
   assign is_therm = (rsp_reading_kind == KIND_THERMISTOR);
   assign has_temp = (rsp_temp_status != ST_NONE);
   assign is_valve = (rsp_reading_kind == KIND_VALVE);
   assign rsp_word = {rsp_channel_out, rsp_reading_kind, rsp_average_q4,
                      rsp_temperature_centi, rsp_temp_status, rsp_valve_position_q8};

   `AWNC_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid, "response dropped while stalled")
   `AWNC_ASSERT(a_rsp_stable, rsp_held |=> $stable(rsp_word), "stalled response changed")
   `AWNC_ASSERT(a_kind_status, rsp_valid |-> (is_therm == has_temp), "status disagrees with kind")
   `AWNC_ASSERT(a_valve_zero, rsp_valid && !is_valve |-> !(|rsp_valve_position_q8), "valve on other kind")
   `AWNC_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid, "response right after reset")
endmodule

bind adc_window_average_ntc_convert_top awnc_checker u_awnc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_channel_out       (rsp_channel_out),
   .rsp_reading_kind      (rsp_reading_kind),
   .rsp_average_q4        (rsp_average_q4),
   .rsp_temperature_centi (rsp_temperature_centi),
   .rsp_temp_status       (rsp_temp_status),
   .rsp_valve_position_q8 (rsp_valve_position_q8)
);
